@@ sv/pitt_pkg.sv @@
`timescale 1ns / 1ps
package pitt_pkg;
    localparam int NUM_BINS      = 4;
    localparam int BIN_W         = $clog2(NUM_BINS);
    localparam int ACT_W         = $clog2(NUM_BINS + 1);
    localparam int IDS_PER_BIN   = 255;
    localparam int SLOT_W        = 8;
    localparam int ADDR_W        = BIN_W + SLOT_W;
    localparam int NUM_ENTRIES   = NUM_BINS << SLOT_W;
    localparam int DISC_W        = 10;
    localparam logic [15:0] TIMEOUT_RESET = 16'd600;

    localparam logic [1:0] CMD_ALLOC   = 2'd0;
    localparam logic [1:0] CMD_RELEASE = 2'd1;
    localparam logic [1:0] CMD_LOOKUP  = 2'd2;
    localparam logic [1:0] CMD_SWEEP   = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOMATCH = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic [7:0]  kind;
        logic [31:0] ref_num;
        logic [15:0] vehicle;
        logic [31:0] stamp;
    } t_entry;

    typedef enum logic [4:0] {
        S_CLR,
        S_IDLE,
        S_ALLOC,
        S_FIT_START,
        S_FIT_RD,
        S_FIT_CHK,
        S_SWAP_RD,
        S_SWAP_CHK,
        S_SWAP_WR2,
        S_SWP_BIN,
        S_SWP_RD,
        S_SWP_CHK,
        S_SWP_END,
        S_MATCH_RD,
        S_MATCH_CHK,
        S_REL_END,
        S_DONE
    } t_state;
endpackage

@@ sv/packet_id_tag_tracker.sv @@
`timescale 1ns / 1ps
// Outstanding tag tracker: ids 1..255 in up to four bins held in one 1024-entry memory with a
// single read and a single write port. Every slot probe sets the address and then uses the
// registered read data, so a lookup or release probes up to one slot per active bin, an
// allocate probes the slots tried by the next-fit search (up to 255) plus one per later bin
// checked for a swap, and an age sweep probes every slot of each active bin. After reset the
// block clears the memory before it takes its first item. A new item is taken while a result waits.
module packet_id_tag_tracker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [1:0]  s_axis_tuser,  // cmd
    input  logic [95:0] s_axis_tdata,  // pkt_kind, ref_number, vehicle, tag_id, now_seconds
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata   // status, assigned_id, found_kind, found_ref,
                                       // discarded_count, zero pad
);
    import pitt_pkg::*;

    t_entry r_mem [NUM_ENTRIES];
    t_entry r_rd;
    logic              w_en;
    logic [ADDR_W-1:0] w_addr;
    t_entry            w_data;
    logic [ADDR_W-1:0] rd_addr;

    t_state r_state, n_state;
    logic [ADDR_W-1:0] r_clr, n_clr;
    logic [1:0]  r_cmd, n_cmd;
    logic [7:0]  r_kind, n_kind;
    logic [31:0] r_ref, n_ref;
    logic [15:0] r_veh, n_veh;
    logic [7:0]  r_id, n_id;
    logic [31:0] r_now, n_now;
    logic [15:0] r_timeout, n_timeout;
    logic [7:0]  r_free [NUM_BINS];
    logic [7:0]  n_free [NUM_BINS];
    logic [7:0]  r_nf [NUM_BINS];
    logic [7:0]  n_nf [NUM_BINS];
    logic [BIN_W-1:0] r_order [NUM_BINS];
    logic [BIN_W-1:0] n_order [NUM_BINS];
    logic [ACT_W-1:0] r_active, n_active;
    logic [ACT_W-1:0] r_pos, n_pos;
    logic [ACT_W-1:0] r_q, n_q;
    logic [BIN_W-1:0] r_tpos, n_tpos;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [SLOT_W-1:0] r_n, n_n;
    logic [DISC_W-1:0] r_disc, n_disc;
    logic r_from_alloc, n_from_alloc;
    logic r_swept, n_swept;
    t_entry r_sw, n_sw;
    logic [1:0]  r_status, n_status;
    logic [7:0]  r_assigned, n_assigned;
    logic [7:0]  r_fkind, n_fkind;
    logic [31:0] r_fref, n_fref;
    logic        r_ovalid, n_ovalid;
    logic [63:0] r_odata, n_odata;

    logic in_fire, out_free;
    logic [BIN_W-1:0] cur_bin, alloc_bin, swap_bin, fwr_pos, unused_bin;
    logic fwr_ok;
    logic [32:0] age_diff;
    logic aged, sw_hit, mt_hit, pos_lt_act, q_lt_act, drop_ok;
    logic [7:0] filt;
    logic [SLOT_W-1:0] slot_next;

    assign in_fire    = s_axis_tvalid && s_axis_tready;
    assign out_free   = !r_ovalid || m_axis_tready;
    assign cur_bin    = r_order[r_pos[BIN_W-1:0]];
    assign alloc_bin  = r_order[r_tpos];
    assign swap_bin   = r_order[r_q[BIN_W-1:0]];
    assign pos_lt_act = r_pos < r_active;
    assign q_lt_act   = r_q < r_active;
    assign age_diff   = {1'b0, r_now} - {1'b0, r_rd.stamp};
    assign aged       = (r_rd.kind != 8'd0) && ($signed(age_diff) > $signed({17'd0, r_timeout}));
    assign sw_hit     = (r_rd.kind != 8'd0) && (r_rd.vehicle == r_veh) && (r_now > r_rd.stamp);
    assign filt       = (r_cmd == CMD_LOOKUP) ? r_kind : 8'd0;
    assign mt_hit     = (r_rd.kind != 8'd0) && (r_rd.vehicle == r_veh)
                        && ((filt == 8'd0) || (r_rd.kind == filt));
    assign drop_ok    = (r_pos != '0) && (r_free[cur_bin] >= 8'(IDS_PER_BIN));
    assign slot_next  = (r_slot >= SLOT_W'(IDS_PER_BIN)) ? SLOT_W'(1) : r_slot + SLOT_W'(1);

    always_comb begin
        fwr_ok  = 1'b0;
        fwr_pos = '0;
        for (int q = NUM_BINS - 1; q >= 0; q--) begin
            if ((ACT_W'(q) < r_active) && (r_free[r_order[q]] != 8'd0)) begin
                fwr_ok  = 1'b1;
                fwr_pos = BIN_W'(q);
            end
        end
    end

    always_comb begin
        logic used;
        unused_bin = '0;
        for (int u = NUM_BINS - 1; u >= 0; u--) begin
            used = 1'b0;
            for (int q = 0; q < NUM_BINS; q++) begin
                if ((ACT_W'(q) < r_active) && (r_order[q] == BIN_W'(u))) begin
                    used = 1'b1;
                end
            end
            if (!used) begin
                unused_bin = BIN_W'(u);
            end
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLR: begin
                if (r_clr == ADDR_W'(NUM_ENTRIES - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (in_fire) begin
                    case (s_axis_tuser)
                        CMD_ALLOC:   n_state = (s_axis_tdata[7:0] != 8'd0) ? S_ALLOC : S_DONE;
                        CMD_SWEEP:   n_state = S_SWP_BIN;
                        default: begin
                            n_state = ((s_axis_tdata[63:56] != 8'd0)
                                       && (s_axis_tdata[63:56] <= 8'(IDS_PER_BIN)))
                                      ? S_MATCH_RD : S_DONE;
                        end
                    endcase
                end
            end
            S_ALLOC: begin
                if (fwr_ok) n_state = S_FIT_START;
                else if (!r_swept) n_state = S_SWP_BIN;
                else if (r_active < ACT_W'(NUM_BINS)) n_state = S_FIT_START;
                else n_state = S_DONE;
            end
            S_FIT_START: n_state = S_FIT_RD;
            S_FIT_RD:    n_state = S_FIT_CHK;
            S_FIT_CHK: begin
                if (r_rd.kind == 8'd0) n_state = S_SWAP_RD;
                else if (r_n == SLOT_W'(IDS_PER_BIN - 1)) n_state = S_DONE;
                else n_state = S_FIT_RD;
            end
            S_SWAP_RD:  n_state = q_lt_act ? S_SWAP_CHK : S_DONE;
            S_SWAP_CHK: n_state = sw_hit ? S_SWAP_WR2 : S_SWAP_RD;
            S_SWAP_WR2: n_state = S_DONE;
            S_SWP_BIN: begin
                if (pos_lt_act) n_state = S_SWP_RD;
                else n_state = r_from_alloc ? S_ALLOC : S_DONE;
            end
            S_SWP_RD:  n_state = S_SWP_CHK;
            S_SWP_CHK: n_state = (r_slot >= SLOT_W'(IDS_PER_BIN)) ? S_SWP_END : S_SWP_RD;
            S_SWP_END: n_state = S_SWP_BIN;
            S_MATCH_RD: n_state = pos_lt_act ? S_MATCH_CHK : S_DONE;
            S_MATCH_CHK: begin
                if (!mt_hit) n_state = S_MATCH_RD;
                else n_state = (r_cmd == CMD_LOOKUP) ? S_DONE : S_REL_END;
            end
            S_REL_END: n_state = S_DONE;
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_clr = r_clr;  n_cmd = r_cmd;  n_kind = r_kind;  n_ref = r_ref;  n_veh = r_veh;
        n_id = r_id;  n_now = r_now;  n_timeout = r_timeout;
        n_free = r_free;  n_nf = r_nf;  n_order = r_order;  n_active = r_active;
        n_pos = r_pos;  n_q = r_q;  n_tpos = r_tpos;  n_slot = r_slot;  n_n = r_n;
        n_disc = r_disc;  n_from_alloc = r_from_alloc;  n_swept = r_swept;  n_sw = r_sw;
        n_status = r_status;  n_assigned = r_assigned;  n_fkind = r_fkind;  n_fref = r_fref;
        n_ovalid = r_ovalid && !m_axis_tready;
        n_odata = r_odata;
        w_en = 1'b0;  w_addr = {cur_bin, r_slot};  w_data = '0;
        rd_addr = {cur_bin, r_slot};

        if (i_cfg_wr_en) n_timeout = i_cfg_wr_data;

        case (r_state)
            S_CLR: begin
                w_en   = 1'b1;
                w_addr = r_clr;
                n_clr  = r_clr + ADDR_W'(1);
            end
            S_IDLE: begin
                if (in_fire) begin
                    n_cmd  = s_axis_tuser;
                    n_kind = s_axis_tdata[7:0];
                    n_ref  = s_axis_tdata[39:8];
                    n_veh  = s_axis_tdata[55:40];
                    n_id   = s_axis_tdata[63:56];
                    n_now  = s_axis_tdata[95:64];
                    n_status = ST_NOMATCH;  n_assigned = '0;  n_fkind = '0;  n_fref = '0;
                    n_disc = '0;  n_pos = '0;  n_swept = 1'b0;
                    n_from_alloc = (s_axis_tuser == CMD_ALLOC);
                end
            end
            S_ALLOC: begin
                if (fwr_ok) begin
                    n_tpos = fwr_pos;
                end else if (!r_swept) begin
                    n_swept = 1'b1;
                    n_pos   = '0;
                end else if (r_active < ACT_W'(NUM_BINS)) begin
                    n_free[unused_bin] = 8'(IDS_PER_BIN);
                    n_nf[unused_bin]   = 8'd1;
                    n_order[r_active[BIN_W-1:0]] = unused_bin;
                    n_tpos   = r_active[BIN_W-1:0];
                    n_active = r_active + ACT_W'(1);
                end else begin
                    n_status = ST_FULL;
                end
            end
            S_FIT_START: begin
                n_n = '0;
                if ((r_nf[alloc_bin] < 8'd1) || (r_nf[alloc_bin] > 8'(IDS_PER_BIN)))
                    n_slot = SLOT_W'(1);
                else
                    n_slot = r_nf[alloc_bin];
            end
            S_FIT_RD: begin
                rd_addr = {alloc_bin, r_slot};
            end
            S_FIT_CHK: begin
                if (r_rd.kind == 8'd0) begin
                    n_nf[alloc_bin] = slot_next;
                    if (r_free[alloc_bin] != 8'd0) n_free[alloc_bin] = r_free[alloc_bin] - 8'd1;
                    w_en   = 1'b1;
                    w_addr = {alloc_bin, r_slot};
                    w_data = '{kind: r_kind, ref_num: r_ref, vehicle: r_veh, stamp: r_now};
                    n_status   = ST_OK;
                    n_assigned = r_slot;
                    n_q = ACT_W'(r_tpos) + ACT_W'(1);
                end else if (r_n == SLOT_W'(IDS_PER_BIN - 1)) begin
                    n_status = ST_FULL;
                end else begin
                    n_n    = r_n + SLOT_W'(1);
                    n_slot = slot_next;
                end
            end
            S_SWAP_RD: begin
                rd_addr = {swap_bin, r_slot};
            end
            S_SWAP_CHK: begin
                if (sw_hit) begin
                    n_sw   = r_rd;
                    w_en   = 1'b1;
                    w_addr = {swap_bin, r_slot};
                    w_data = '{kind: r_kind, ref_num: r_ref, vehicle: r_rd.vehicle, stamp: r_now};
                end else begin
                    n_q = r_q + ACT_W'(1);
                end
            end
            S_SWAP_WR2: begin
                w_en   = 1'b1;
                w_addr = {alloc_bin, r_slot};
                w_data = '{kind: r_sw.kind, ref_num: r_sw.ref_num, vehicle: r_veh,
                           stamp: r_sw.stamp};
            end
            S_SWP_BIN: begin
                n_slot = SLOT_W'(1);
                if (!pos_lt_act && !r_from_alloc) n_status = ST_OK;
            end
            S_SWP_CHK: begin
                if (aged) begin
                    w_en = 1'b1;
                    if (r_free[cur_bin] < 8'(IDS_PER_BIN)) n_free[cur_bin] = r_free[cur_bin] + 8'd1;
                    if (r_disc != '1) n_disc = r_disc + DISC_W'(1);
                end
                n_slot = r_slot + SLOT_W'(1);
            end
            S_SWP_END: begin
                if (drop_ok) begin
                    for (int q = 0; q < NUM_BINS - 1; q++) begin
                        if (ACT_W'(q) >= r_pos) n_order[q] = r_order[q + 1];
                    end
                    n_active = r_active - ACT_W'(1);
                end else begin
                    n_pos = r_pos + ACT_W'(1);
                end
            end
            S_MATCH_RD: begin
                rd_addr = {cur_bin, r_id};
            end
            S_MATCH_CHK: begin
                if (mt_hit) begin
                    n_status = ST_OK;
                    if (r_cmd == CMD_LOOKUP) begin
                        n_fkind = r_rd.kind;
                        n_fref  = r_rd.ref_num;
                    end else begin
                        w_en   = 1'b1;
                        w_addr = {cur_bin, r_id};
                        if (r_free[cur_bin] < 8'(IDS_PER_BIN)) n_free[cur_bin] = r_free[cur_bin] + 8'd1;
                    end
                end else begin
                    n_pos = r_pos + ACT_W'(1);
                end
            end
            S_REL_END: begin
                if (drop_ok) begin
                    for (int q = 0; q < NUM_BINS - 1; q++) begin
                        if (ACT_W'(q) >= r_pos) n_order[q] = r_order[q + 1];
                    end
                    n_active = r_active - ACT_W'(1);
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_odata  = {4'd0, r_disc, r_fref, r_fkind, r_assigned, r_status};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) r_mem[w_addr] <= w_data;
        r_rd <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_clr     <= '0;
            r_timeout <= TIMEOUT_RESET;
            r_active  <= ACT_W'(1);
            r_ovalid  <= 1'b0;
            for (int b = 0; b < NUM_BINS; b++) begin
                r_free[b]  <= 8'(IDS_PER_BIN);
                r_nf[b]    <= 8'd1;
                r_order[b] <= BIN_W'(b);
            end
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_timeout <= n_timeout;
            r_active  <= n_active;
            r_ovalid  <= n_ovalid;
            r_free    <= n_free;
            r_nf      <= n_nf;
            r_order   <= n_order;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;  r_kind <= n_kind;  r_ref <= n_ref;  r_veh <= n_veh;
        r_id <= n_id;  r_now <= n_now;  r_pos <= n_pos;  r_q <= n_q;  r_tpos <= n_tpos;
        r_slot <= n_slot;  r_n <= n_n;  r_disc <= n_disc;  r_from_alloc <= n_from_alloc;
        r_swept <= n_swept;  r_sw <= n_sw;  r_status <= n_status;
        r_assigned <= n_assigned;  r_fkind <= n_fkind;  r_fref <= n_fref;  r_odata <= n_odata;
    end
endmodule

@@ sv/pitt_checker.sv @@
`timescale 1ns / 1ps
module pitt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata
);
    import pitt_pkg::*;

    a_busy_after_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("ready right after an item");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && !s_axis_tready)
        else $error("active after reset");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3)
        else $error("bad status code");

    a_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[1:0] != ST_OK) |-> m_axis_tdata[49:10] == 40'd0)
        else $error("found fields set on failure");
endmodule

bind packet_id_tag_tracker pitt_checker u_pitt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
